/* rtl/bmhq_pkg.sv */
`timescale 1ns / 1ps

package bmhq_pkg;

    // Item kind carried on the slave-side tuser
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result status carried on the master-side tuser
    typedef logic [1:0] t_status;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

endpackage

/* rtl/binary_max_heap_queue.sv */
`timescale 1ns / 1ps

// Max priority queue built as a one-based binary heap held in a single synchronous RAM
// with two read ports and one write port. An insert transaction (tuser = 0) stores the
// key and swims it up. A remove transaction (tuser = 1) returns the largest key, moves
// the last entry to the root and sinks it. Each transaction yields exactly one result
// carrying the removed key (zero unless a remove succeeded), a status on tuser (ok,
// empty on remove, or full on insert) and the entry count after the operation.
// Items are handled one at a time. An insert reads and compares the parent at each level
// swum and then writes the key at its final slot. A remove reads the root and the last
// entry together, then reads and compares both children at each level sunk; removing the
// only key skips the sink. Empty and full results go straight to the output register.
// The input is ready again in the cycle the result appears on the output. The worst case
// is an insert that climbs from the last slot to the root. Its length is set by the
// read-compare-write loop over the heap RAM, where each level waits for the registered
// read data. A result held back by the receiver stalls the next transaction.
// The RAM needs no clearing after reset: only slots below the count are ever used.
module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32,
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int ADDR_W   = $clog2(CAPACITY),
    localparam int IN_W     = ((KEY_WIDTH + 7) / 8) * 8,
    localparam int OUT_W    = ((KEY_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // key
    input  logic             s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // max_key, entry_count
    output t_status          m_axis_tuser    // status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_RD  = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_RM_LD  = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    // Heap RAM, slot p (one-based) lives at address p-1
    logic [KEY_WIDTH-1:0] r_heap [CAPACITY];
    logic [KEY_WIDTH-1:0] r_rd_a;
    logic [KEY_WIDTH-1:0] r_rd_b;

    logic [2:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_pos, n_pos;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [KEY_WIDTH-1:0] r_res_key, n_res_key;
    t_status              r_res_status, n_res_status;
    logic                 r_m_valid, n_m_valid;
    logic [KEY_WIDTH-1:0] r_m_key, n_m_key;
    t_status              r_m_status, n_m_status;
    logic [CNT_W-1:0]     r_m_count, n_m_count;

    logic                 w_we;
    logic [ADDR_W-1:0]    w_waddr;
    logic [KEY_WIDTH-1:0] w_wdata;
    logic [ADDR_W-1:0]    w_raddr_a;
    logic [ADDR_W-1:0]    w_raddr_b;

    logic                 w_accept;
    logic [CNT_W-1:0]     w_parent;
    logic [ADDR_W-1:0]    w_pos_addr;
    logic [CNT_W:0]       w_child;
    logic                 w_right;
    logic [KEY_WIDTH-1:0] w_pick_key;
    logic [CNT_W-1:0]     w_pick_pos;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_W'({r_m_count, r_m_key});
    assign m_axis_tuser  = r_m_status;

    // Heap navigation from the current hole position
    assign w_parent   = r_pos >> 1;
    assign w_pos_addr = ADDR_W'(r_pos - CNT_W'(1));
    assign w_child    = {r_pos, 1'b0};
    assign w_right    = (w_child < {1'b0, r_count}) && (r_rd_a < r_rd_b);
    assign w_pick_key = w_right ? r_rd_b : r_rd_a;
    assign w_pick_pos = CNT_W'(w_child + (CNT_W + 1)'(w_right));

    // Sequencer: the moving key stays in r_key and is written once at its final slot,
    // while displaced entries move into the hole. Swim and sink reads always target the parent
    // or the children of the hole, never a slot written in the same pass, so no forwarding.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_key        = r_key;
        n_res_key    = r_res_key;
        n_res_status = r_res_status;
        n_m_valid    = r_m_valid;
        n_m_key      = r_m_key;
        n_m_status   = r_m_status;
        n_m_count    = r_m_count;
        w_we         = 1'b0;
        w_waddr      = w_pos_addr;
        w_wdata      = r_key;
        w_raddr_a    = '0;
        w_raddr_b    = '0;

        // drop the result once taken
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_key    = '0;
                    n_res_status = ST_OK;
                    n_key        = s_axis_tdata[KEY_WIDTH-1:0];
                    if (s_axis_tuser == KIND_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_res_status = ST_FULL;
                            n_state      = S_OUT;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_pos   = r_count + CNT_W'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_OUT;
                        end else begin
                            // fetch root and last entry together
                            w_raddr_a = '0;
                            w_raddr_b = ADDR_W'(r_count - CNT_W'(1));
                            n_state   = S_RM_LD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == CNT_W'(1)) begin
                    w_we    = 1'b1;
                    n_state = S_OUT;
                end else begin
                    w_raddr_a = ADDR_W'(w_parent - CNT_W'(1));
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (r_rd_a < r_key) begin
                    // move parent down into the hole and climb
                    w_wdata = r_rd_a;
                    n_pos   = w_parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RM_LD: begin
                n_res_key = r_rd_a;
                n_key     = r_rd_b;
                n_count   = r_count - CNT_W'(1);
                n_pos     = CNT_W'(1);
                n_state   = (r_count == CNT_W'(1)) ? S_OUT : S_DN_RD;
            end
            S_DN_RD: begin
                if (w_child > {1'b0, r_count}) begin
                    w_we    = 1'b1;
                    n_state = S_OUT;
                end else begin
                    w_raddr_a = ADDR_W'(w_child - (CNT_W + 1)'(1));
                    w_raddr_b = ADDR_W'(w_child);
                    n_state   = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (r_key < w_pick_key) begin
                    // move larger child up into the hole and descend
                    w_wdata = w_pick_key;
                    n_pos   = w_pick_pos;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // load the output register once it is free
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_key    = r_res_key;
                    n_m_status = r_res_status;
                    n_m_count  = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Heap RAM: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_heap[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_heap[w_raddr_a];
        r_rd_b <= r_heap[w_raddr_b];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_res_key    <= n_res_key;
        r_res_status <= n_res_status;
        r_m_key      <= n_m_key;
        r_m_status   <= n_m_status;
        r_m_count    <= n_m_count;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("heap count exceeds capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_status == ST_FULL) |-> (r_m_count == CNT_W'(CAPACITY)))
        else $error("full status with a queue that is not full");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_status == ST_EMPTY) |-> (r_m_count == '0 && r_m_key == '0))
        else $error("empty status with keys held or a nonzero key");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state != S_IDLE && r_state != S_OUT && r_state != S_RM_LD))
        else $error("heap RAM written outside an insert or sink pass");
`endif

endmodule
